// ===== design/hftp_pkg.sv =====
// Shared constants, types and helpers for the heading-from-two-points pipeline.
package hftp_pkg;

    // Coordinate and pipeline sizing
    localparam int COORD_WIDTH   = 16;
    localparam int CORDIC_STAGES = 18;
    localparam int FIELD_W       = 16;
    localparam int DIFF_W        = COORD_WIDTH + 1;

    // CORDIC datapath: magnitudes sit at bit 60, gain and sqrt(2) need two more bits plus sign
    localparam int PRE_SHIFT     = 60 - COORD_WIDTH;
    localparam int CORDIC_W      = 63;

    // Angles in degrees with 16 fractional bits
    localparam int ANG_FRAC      = 16;
    localparam int ACC_W         = 25;
    localparam int V_W           = 25;
    localparam int HEAD_FRAC     = 8;
    localparam int ROUND_SHIFT   = ANG_FRAC - HEAD_FRAC;
    localparam int HEAD_W        = 17;

    // Stream widths
    localparam int IN_TDATA_W    = 4 * FIELD_W;
    localparam int OUT_TDATA_W   = ((HEAD_W + 7) / 8) * 8;

    localparam logic [V_W-1:0] DEG_90     = V_W'(90 << ANG_FRAC);
    localparam logic [V_W-1:0] DEG_180    = V_W'(180 << ANG_FRAC);
    localparam logic [V_W-1:0] DEG_270    = V_W'(270 << ANG_FRAC);
    localparam logic [V_W-1:0] DEG_360    = V_W'(360 << ANG_FRAC);
    localparam logic [V_W-1:0] ROUND_HALF = V_W'(1 << (ROUND_SHIFT - 1));
    localparam logic [HEAD_W-1:0] HEAD_WRAP = HEAD_W'(360 << HEAD_FRAC);

    // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
    localparam logic signed [ACC_W-1:0] ATAN_DEG [0:31] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0,
        25'sd0,       25'sd0,       25'sd0,      25'sd0,
        25'sd0,       25'sd0,       25'sd0,      25'sd0
    };

    // Exact headings for points on an axis
    typedef enum logic [1:0] {
        SPEC_0,
        SPEC_90,
        SPEC_180,
        SPEC_270
    } t_spec;

    typedef struct packed {
        logic  special;
        t_spec spec;
        logic  dz_pos;
        logic  dx_neg;
    } t_side;

    function automatic logic signed [DIFF_W-1:0] sext_coord(input logic [COORD_WIDTH-1:0] v);
        return DIFF_W'(signed'(v));
    endfunction

    function automatic logic [V_W-1:0] spec_value(input t_spec s);
        logic [V_W-1:0] v;
        unique case (s)
            SPEC_0:   v = '0;
            SPEC_90:  v = DEG_90;
            SPEC_180: v = DEG_180;
            SPEC_270: v = DEG_270;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/heading_from_two_points_top.sv =====
// Pipelined vectoring CORDIC that turns a start/target point pair into a compass heading.
//
//  channel   | dir | payload (tdata, low bit first)                     | handshake
//  ----------+-----+----------------------------------------------------+-------------------
//  s_axis    | in  | from_x[15:0] from_z[31:16] target_x[47:32]         | tvalid & tready
//            |     | target_z[63:48]                                    |
//  m_axis    | out | heading[16:0] (1/256 degree), zeros [23:17]        | tvalid & tready
//
//  One item enters per cycle while the skid register is empty; each passes through
//  CORDIC_STAGES + 4 registers: difference stage, one register per CORDIC iteration,
//  fold, round, output.
//  The whole pipeline advances together; it stops only while the output skid register is
//  occupied, so an item is still taken while a single result waits downstream.
//  i_rst_n is synchronous, active low, and clears only the valid flags.
module heading_from_two_points_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // from_x[15:0], from_z[31:16], target_x[47:32], target_z[63:48]
    input  logic [hftp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // heading[16:0], zero padding [23:17]
    output logic [hftp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import hftp_pkg::*;

    // Stage index of the last pipeline register (rounded heading)
    localparam int LAST_STG  = CORDIC_STAGES + 2;

    // Pipeline advance: everything moves unless the skid slot is full
    logic en;
    logic deliver;

    logic [LAST_STG:0] r_vld;

    // Per-stage CORDIC state; stage 0 is the difference stage
    logic signed [CORDIC_W-1:0] r_x   [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] r_y   [0:CORDIC_STAGES];
    logic signed [ACC_W-1:0]    r_acc [0:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] n_x   [1:CORDIC_STAGES];
    logic signed [CORDIC_W-1:0] n_y   [1:CORDIC_STAGES];
    logic signed [ACC_W-1:0]    n_acc [1:CORDIC_STAGES];
    t_side                      r_side [0:CORDIC_STAGES];

    logic [V_W-1:0]    r_v;
    logic [V_W-1:0]    n_v;
    logic [HEAD_W-1:0] r_h;
    logic [HEAD_W-1:0] n_h;

    // Output register and skid slot
    logic              r_out_vld;
    logic [HEAD_W-1:0] r_out_h;
    logic              r_skid_vld;
    logic [HEAD_W-1:0] r_skid_h;

    // Difference stage signals
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dz;
    logic [DIFF_W-1:0]        abs_dx;
    logic [DIFF_W-1:0]        abs_dz;
    t_side                    n_side;

    assign en            = !r_skid_vld;
    assign deliver       = en && r_vld[LAST_STG];
    assign s_axis_tready = en;

    // ---------------------------------------------------------------- differences
    always_comb begin
        dx = sext_coord(s_axis_tdata[2*FIELD_W +: COORD_WIDTH])
           - sext_coord(s_axis_tdata[0*FIELD_W +: COORD_WIDTH]);
        dz = sext_coord(s_axis_tdata[3*FIELD_W +: COORD_WIDTH])
           - sext_coord(s_axis_tdata[1*FIELD_W +: COORD_WIDTH]);
        abs_dx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        abs_dz = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

        n_side.dz_pos  = !dz[DIFF_W-1] && (dz != '0);
        n_side.dx_neg  = dx[DIFF_W-1];
        n_side.special = (dx == '0) || (dz == '0);
        // Same x: toward +z is 180, else 0. Same z: toward +x is 90, else 270.
        if (dx == '0) begin
            n_side.spec = n_side.dz_pos ? SPEC_180 : SPEC_0;
        end else begin
            n_side.spec = dx[DIFF_W-1] ? SPEC_270 : SPEC_90;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // |dz| drives x, |dx| drives y: the angle is atan(|dx|/|dz|)
            r_x[0]    <= CORDIC_W'(abs_dz) << PRE_SHIFT;
            r_y[0]    <= CORDIC_W'(abs_dx) << PRE_SHIFT;
            r_acc[0]  <= '0;
            r_side[0] <= n_side;
        end
    end

    // ---------------------------------------------------------------- CORDIC iterations
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_iter
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;

        always_comb begin
            xs = r_x[g] >>> g;
            ys = r_y[g] >>> g;
            // Rotate toward the x axis; y of zero counts as not positive
            if (!r_y[g][CORDIC_W-1] && (r_y[g] != '0)) begin
                n_x[g+1]   = r_x[g] + ys;
                n_y[g+1]   = r_y[g] - xs;
                n_acc[g+1] = r_acc[g] + ATAN_DEG[g];
            end else begin
                n_x[g+1]   = r_x[g] - ys;
                n_y[g+1]   = r_y[g] + xs;
                n_acc[g+1] = r_acc[g] - ATAN_DEG[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_x[g+1]    <= n_x[g+1];
                r_y[g+1]    <= n_y[g+1];
                r_acc[g+1]  <= n_acc[g+1];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    // ---------------------------------------------------------------- clamp and fold
    always_comb begin
        logic [V_W-1:0] f;
        t_side          sd;
        sd = r_side[CORDIC_STAGES];
        // Clamp the angle to 0..90 degrees
        if (r_acc[CORDIC_STAGES][ACC_W-1]) begin
            f = '0;
        end else if (V_W'(r_acc[CORDIC_STAGES]) > DEG_90) begin
            f = DEG_90;
        end else begin
            f = V_W'(r_acc[CORDIC_STAGES]);
        end

        if (sd.special) begin
            n_v = spec_value(sd.spec);
        end else if (sd.dz_pos) begin
            n_v = sd.dx_neg ? DEG_180 + f : DEG_180 - f;
        end else begin
            n_v = sd.dx_neg ? DEG_360 - f : f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v <= n_v;
        end
    end

    // ---------------------------------------------------------------- round and wrap
    always_comb begin
        logic [V_W-1:0] sum;
        sum = r_v + ROUND_HALF;
        n_h = sum[ROUND_SHIFT +: HEAD_W];
        // 360.0 after rounding wraps to 0
        if (n_h >= HEAD_WRAP) begin
            n_h = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h <= n_h;
        end
    end

    // ---------------------------------------------------------------- valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST_STG-1:0], s_axis_tvalid};
        end
    end

    // ---------------------------------------------------------------- output with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && !m_axis_tready) begin
            // Hold the output; park a newly finished item in the skid slot
            if (deliver) begin
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld <= deliver;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && !m_axis_tready) begin
            if (deliver) begin
                r_skid_h <= r_h;
            end
        end else if (r_skid_vld) begin
            r_out_h <= r_skid_h;
        end else if (deliver) begin
            r_out_h <= r_h;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_h);

endmodule

// ===== design/hftp_checker.sv =====
// Port-level checks for the heading pipeline, bound to the top level.
module hftp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [hftp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [hftp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import hftp_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Headings stay below 360 degrees
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[HEAD_W-1:0] < HEAD_WRAP))
        else $error("heading out of range");

    // Padding bits above the heading are zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:HEAD_W] == '0))
        else $error("nonzero tdata padding");

    // Input backpressure only happens with a result waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind heading_from_two_points_top hftp_checker u_hftp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/heading_checker.sv =====
// Scoreboard for the heading pipeline: predicts each heading and compares results in order.
module heading_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // from_x[15:0], from_z[31:16], target_x[47:32], target_z[63:48]
    input  logic [hftp_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // heading[16:0], zero padding [23:17]
    input  logic [hftp_pkg::OUT_TDATA_W-1:0]  i_m_tdata,
    output int                                o_fail_count,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAG_SHIFT   = 60 - hftp_pkg::COORD_WIDTH;
    localparam int ITERATIONS  = hftp_pkg::CORDIC_STAGES;
    localparam int FULL_CIRCLE = 360 * 256;

    // atan(2^-k) in degrees, 16 fractional bits
    localparam longint ARCTAN_STEP [0:31] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    logic [hftp_pkg::HEAD_W-1:0] expected_headings [$];
    int                          mismatches;

    // Angle of |dx| over |dz| in Q16 degrees, both magnitudes nonzero.
    function automatic longint vector_angle(input longint az, input longint ax);
        longint x, y, xs, ys, acc;
        acc = 0;
        x   = az <<< MAG_SHIFT;
        y   = ax <<< MAG_SHIFT;
        for (int k = 0; k < ITERATIONS && k < 32; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + ARCTAN_STEP[k];
            end else begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - ARCTAN_STEP[k];
            end
        end
        if (acc < 0)
            acc = 0;
        if (acc > (longint'(90) <<< 16))
            acc = longint'(90) <<< 16;
        return acc;
    endfunction

    function automatic logic [hftp_pkg::HEAD_W-1:0] predict_heading(
        input logic [hftp_pkg::IN_TDATA_W-1:0] pts
    );
        longint dx, dz, turn, v, h;
        dx = longint'(signed'(pts[47:32])) - longint'(signed'(pts[15:0]));
        dz = longint'(signed'(pts[63:48])) - longint'(signed'(pts[31:16]));
        if (dx == 0) begin
            v = (dz > 0) ? (longint'(180) <<< 16) : 0;
        end else if (dz == 0) begin
            v = (dx > 0) ? (longint'(90) <<< 16) : (longint'(270) <<< 16);
        end else begin
            turn = vector_angle((dz < 0) ? -dz : dz, (dx < 0) ? -dx : dx);
            if (dz > 0)
                v = (dx < 0) ? (longint'(180) <<< 16) + turn : (longint'(180) <<< 16) - turn;
            else
                v = (dx < 0) ? (longint'(360) <<< 16) - turn : turn;
        end
        // round to 1/256 degree, fold 360.0 back to zero
        h = (v + 128) >>> 8;
        if (h >= FULL_CIRCLE)
            h = 0;
        return h[hftp_pkg::HEAD_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [hftp_pkg::HEAD_W-1:0]     want;
        logic [hftp_pkg::OUT_TDATA_W-1:0] want_word;
        if (!i_rst_n) begin
            mismatches   = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            // retire the oldest expectation first; no item can leave in the same cycle it enters
            if (i_m_tvalid && i_m_tready) begin
                if (expected_headings.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected heading expected none actual %0d",
                             $time, i_m_tdata[hftp_pkg::HEAD_W-1:0]);
                end else begin
                    want      = expected_headings.pop_front();
                    want_word = hftp_pkg::OUT_TDATA_W'(want);
                    if (i_m_tdata !== want_word) begin
                        mismatches++;
                        $display("%0t: heading mismatch expected 0x%06h actual 0x%06h",
                                 $time, want_word, i_m_tdata);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_headings.push_back(predict_heading(i_s_tdata));
            o_fail_count <= mismatches;
            o_pending    <= expected_headings.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the heading pipeline testbench: clock, reset, point stimulus, output pacing, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1950;
    localparam int STALL_LIMIT  = 3000;   // idle cycles before the run is declared hung
    localparam int DRAIN_CYCLES = 40;     // pipeline is 22 deep, leave margin for stray results
    localparam int HOLD_CYCLES  = 400;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    // from_x[15:0], from_z[31:16], target_x[47:32], target_z[63:48]
    logic [hftp_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    // heading[16:0], zero padding [23:17]
    logic [hftp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int quiet_cycles;

    heading_from_two_points_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    heading_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hang detector: count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Output side: random back-pressure, plus one long hold-off when asked.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one point pair and hold it until the block takes it.
    // Call only just after the clock rises.
    task automatic offer_points(input logic [15:0] fx, input logic [15:0] fz,
                                input logic [15:0] tx, input logic [15:0] tz);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tz, tx, fz, fx};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Target as start plus a signed offset; deltas wrap at 16 bits like any other value.
    task automatic offer_offset(input logic [15:0] fx, input logic [15:0] fz,
                                input int ox, input int oz);
        offer_points(fx, fz, fx + 16'(ox), fz + 16'(oz));
    endtask

    // Random offset whose magnitude spans a random number of bits.
    function automatic int random_offset();
        int bits;
        int mag;
        bits = $urandom_range(1, 16);
        mag  = $urandom_range(0, (1 << bits) - 1);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic offer_random_pair();
        logic [15:0] fx, fz;
        int          kind;
        fx   = 16'($urandom);
        fz   = 16'($urandom);
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            offer_points(fx, fz, 16'($urandom), 16'($urandom));
        end else if (kind < 75) begin
            offer_offset(fx, fz, random_offset(), random_offset());
        end else if (kind < 83) begin
            // on an axis: same x or same z
            if ($urandom_range(0, 1))
                offer_offset(fx, fz, 0, random_offset());
            else
                offer_offset(fx, fz, random_offset(), 0);
        end else if (kind < 87) begin
            offer_points(fx, fz, fx, fz);
        end else if (kind < 93) begin
            // nearly on an axis, where rounding and the wrap at 360 bite
            if ($urandom_range(0, 1))
                offer_offset(fx, fz, $urandom_range(0, 1) ? 1 : -1, random_offset());
            else
                offer_offset(fx, fz, random_offset(), $urandom_range(0, 1) ? 1 : -1);
        end else begin
            // corners of the coordinate range
            offer_points($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                         $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                         $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                         $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
        end
    endtask

    initial begin
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_rst_n        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: equal points, each axis direction, extreme and tiny differences.
        offer_points(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        offer_points(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        offer_points(16'h1234, 16'h0000, 16'h1234, 16'h0001);  // due increasing z
        offer_points(16'h1234, 16'h0001, 16'h1234, 16'h0000);  // due decreasing z
        offer_points(16'h0000, 16'h5555, 16'h0001, 16'h5555);  // due increasing x
        offer_points(16'h0001, 16'h5555, 16'h0000, 16'h5555);  // due decreasing x
        offer_points(16'h8000, 16'h8000, 16'h7FFF, 16'h8000);  // widest x step
        offer_points(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        offer_points(16'h8000, 16'h8000, 16'h8000, 16'h7FFF);  // widest z step
        offer_points(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        offer_points(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);  // diagonals at full span
        offer_points(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
        offer_points(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        offer_points(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        offer_offset(16'h0000, 16'h0000, 1, 1);
        offer_offset(16'h0000, 16'h0000, 1, -1);
        offer_offset(16'h0000, 16'h0000, -1, 1);
        offer_offset(16'h0000, 16'h0000, -1, -1);
        offer_points(16'h7FFF, 16'h7FFF, 16'h7FFE, 16'h8000);  // just short of 360, wraps to 0
        offer_points(16'h8000, 16'h8000, 16'h8001, 16'h7FFF);  // just short of 180
        offer_points(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFE);  // just short of 90
        offer_points(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        offer_points(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);

        // Random phases: free flow, slow sender, slow receiver, both a little.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                // Fill the pipeline against a held-off output while items keep coming.
                if (phase == 0 && n == 100)
                    hold_request = HOLD_CYCLES;
                offer_random_pair();
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain; the hang detector ends the run if results stop arriving.
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
